### hw/rtl/ptc_pkg.sv
// Shared types and codes for the PTAT/CTAT temperature calculator.
// No dependencies.
package ptc_pkg;

  localparam int unsigned CalW = 12;
  localparam int unsigned FracShift = 4;
  localparam int unsigned OutW = 16;

  typedef enum logic [2:0] {
    REG_LOW_TEMP   = 3'd0,
    REG_HIGH_TEMP  = 3'd1,
    REG_PTAT_LOW   = 3'd2,
    REG_PTAT_HIGH  = 3'd3,
    REG_CTAT_LOW   = 3'd4,
    REG_CTAT_HIGH  = 3'd5
  } ptc_reg_e;

  // Sideband carried along the divider row with each item.
  typedef struct packed {
    logic valid;
    logic neg;
    logic err;
  } ptc_side_t;

endpackage

### hw/rtl/ptat_ctat_temperature_calc.sv
// Top level of the PTAT/CTAT two-point calibrated temperature calculator.
// Depends on ptc_pkg and ptc_div_cell.
//
// One item (a CTAT/PTAT sample pair) may be started every clock; busy is
// never raised. Each result passes through three arithmetic stages
// (calibration coefficients, the sample products, the numerator/denominator
// sums), then one restoring division cell per quotient bit, then a
// rounding/saturation stage. done marks a result for one cycle only; the
// receiver cannot hold it off. Calibration registers are written through
// cfg_we_i; the user must write them only while no item is in flight, which
// the block itself does not enforce. Unknown indexes are ignored. A zero
// denominator gives 0 and raises divide_error_o.
module ptat_ctat_temperature_calc #(
  parameter int unsigned ADC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [15:0]               ctat_sample_i,
  input  logic [15:0]               ptat_sample_i,
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_idx_i,
  input  logic [ptc_pkg::CalW-1:0]  cfg_data_i,
  output logic                      done,
  output logic signed [15:0]        temperature_deg_o,
  output logic                      divide_error_o
);
  import ptc_pkg::*;

  // coefficient widths
  localparam int unsigned AW  = 2 * CalW + 1;        // tl*vph - th*vpl
  localparam int unsigned CW  = CalW + 1;            // vcl - vch
  localparam int unsigned SW  = ADC_BITS + 1;        // sample as signed
  localparam int unsigned MW  = AW + SW;             // numerator product
  localparam int unsigned NW  = MW + 1;              // numerator sum
  localparam int unsigned PW  = CW + SW;             // denominator product
  localparam int unsigned DW  = PW + 1;              // denominator sum
  localparam int unsigned LAT = NW + 4;

  // calibration registers
  logic [CalW-1:0] tl_q, th_q, vpl_q, vph_q, vcl_q, vch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tl_q  <= '0;
      th_q  <= '0;
      vpl_q <= '0;
      vph_q <= '0;
      vcl_q <= '0;
      vch_q <= '0;
    end else if (cfg_we_i) begin
      unique case (ptc_reg_e'(cfg_idx_i))
        REG_LOW_TEMP:  tl_q  <= cfg_data_i;
        REG_HIGH_TEMP: th_q  <= cfg_data_i;
        REG_PTAT_LOW:  vpl_q <= cfg_data_i;
        REG_PTAT_HIGH: vph_q <= cfg_data_i;
        REG_CTAT_LOW:  vcl_q <= cfg_data_i;
        REG_CTAT_HIGH: vch_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  logic acc;
  assign acc = start && !busy;

  // stage 1: coefficients, num = a*tc + b*tp, den = c*tp + d*tc
  logic [2*CalW-1:0]    p_tlvph, p_thvpl, p_thvcl, p_tlvch;
  logic signed [AW-1:0] a_d, b_d, a_q, b_q;
  logic signed [CW-1:0] c_d, d_d, c_q, d_q;
  logic [ADC_BITS-1:0]  tc_q, tp_q;
  logic                 v1_q, v2_q, v3_q;

  assign p_tlvph = tl_q * vph_q;
  assign p_thvpl = th_q * vpl_q;
  assign p_thvcl = th_q * vcl_q;
  assign p_tlvch = tl_q * vch_q;
  assign a_d = $signed({1'b0, p_tlvph}) - $signed({1'b0, p_thvpl});
  assign b_d = $signed({1'b0, p_thvcl}) - $signed({1'b0, p_tlvch});
  assign c_d = $signed({1'b0, vcl_q}) - $signed({1'b0, vch_q});
  assign d_d = $signed({1'b0, vph_q}) - $signed({1'b0, vpl_q});

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    b_q  <= b_d;
    c_q  <= c_d;
    d_q  <= d_d;
    tc_q <= ctat_sample_i[ADC_BITS-1:0];
    tp_q <= ptat_sample_i[ADC_BITS-1:0];
  end

  // stage 2: the four sample products
  logic signed [SW-1:0] tcs, tps;
  logic signed [MW-1:0] pa_q, pb_q;
  logic signed [PW-1:0] pc_q, pd_q;

  assign tcs = $signed({1'b0, tc_q});
  assign tps = $signed({1'b0, tp_q});

  always_ff @(posedge clk_i) begin
    pa_q <= a_q * tcs;
    pb_q <= b_q * tps;
    pc_q <= c_q * tps;
    pd_q <= d_q * tcs;
  end

  // stage 3: sums, signs and magnitudes
  logic signed [NW-1:0] num;
  logic signed [DW-1:0] den;
  logic [NW-1:0]        num_mag_q;
  logic [DW-1:0]        den_mag_q;
  logic                 neg_q, err_q;

  assign num = NW'(pa_q) + NW'(pb_q);
  assign den = DW'(pc_q) + DW'(pd_q);

  always_ff @(posedge clk_i) begin
    num_mag_q <= num[NW-1] ? NW'(-num) : NW'(num);
    den_mag_q <= den[DW-1] ? DW'(-den) : DW'(den);
    neg_q     <= num[NW-1] ^ den[DW-1];
    err_q     <= (den == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // divider row, one cell per quotient bit
  ptc_side_t     side [NW+1];
  logic [DW-1:0] rem  [NW+1];
  logic [NW-1:0] dq   [NW+1];
  logic [DW-1:0] dv   [NW+1];

  assign side[0] = '{valid: v3_q, neg: neg_q, err: err_q};
  assign rem[0]  = '0;
  assign dq[0]   = num_mag_q;
  assign dv[0]   = den_mag_q;

  for (genvar g = 0; g < NW; g++) begin : g_cell
    ptc_div_cell #(.NW(NW), .DW(DW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .side_i (side[g]),
      .rem_i  (rem[g]),
      .dq_i   (dq[g]),
      .den_i  (dv[g]),
      .side_o (side[g+1]),
      .rem_o  (rem[g+1]),
      .dq_o   (dq[g+1]),
      .den_o  (dv[g+1])
    );
  end

  // output: sign, floor shift of the 8.4 fraction, saturation
  logic signed [NW:0] q_s, q_sh;
  logic signed [NW:0] lim_hi, lim_lo;
  logic signed [OutW-1:0] t_d, t_q;
  logic done_q, err_out_q;

  assign q_s    = side[NW].neg ? -$signed({1'b0, dq[NW]}) : $signed({1'b0, dq[NW]});
  assign q_sh   = q_s >>> FracShift;
  assign lim_hi = (NW+1)'(32767);
  assign lim_lo = -(NW+1)'(32768);

  always_comb begin
    if (side[NW].err) begin
      t_d = '0;
    end else if (q_sh > lim_hi) begin
      t_d = 16'sh7FFF;
    end else if (q_sh < lim_lo) begin
      t_d = 16'sh8000;
    end else begin
      t_d = q_sh[OutW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    t_q       <= t_d;
    err_out_q <= side[NW].err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= side[NW].valid;
    end
  end

  assign done              = done_q;
  assign temperature_deg_o = t_q;
  assign divide_error_o    = err_out_q;

  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> $past(acc, LAT))
    else $error("result without matching start");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && divide_error_o) |-> (temperature_deg_o == '0))
    else $error("divide error with nonzero temperature");

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(acc, LAT) |-> done)
    else $error("started item lost");

endmodule

### hw/rtl/ptc_div_cell.sv
// One restoring division step: produces one quotient bit per cell.
// Depends on ptc_pkg.
module ptc_div_cell #(
  parameter int unsigned NW = 42,
  parameter int unsigned DW = 30
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptc_pkg::ptc_side_t side_i,
  input  logic [DW-1:0]     rem_i,
  input  logic [NW-1:0]     dq_i,
  input  logic [DW-1:0]     den_i,
  output ptc_pkg::ptc_side_t side_o,
  output logic [DW-1:0]     rem_o,
  output logic [NW-1:0]     dq_o,
  output logic [DW-1:0]     den_o
);
  import ptc_pkg::*;

  logic [DW:0]   pr;
  logic          take;
  logic [DW:0]   diff;
  ptc_side_t     side_q;
  logic [DW-1:0] rem_q, den_q;
  logic [NW-1:0] dq_q;

  assign pr   = {rem_i, dq_i[NW-1]};
  assign diff = pr - {1'b0, den_i};
  assign take = (pr >= {1'b0, den_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= take ? diff[DW-1:0] : pr[DW-1:0];
    dq_q  <= {dq_i[NW-2:0], take};
    den_q <= den_i;
  end

  assign side_o = side_q;
  assign rem_o  = rem_q;
  assign dq_o   = dq_q;
  assign den_o  = den_q;

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (side_q.valid && !side_q.err) |-> (rem_q < den_q))
    else $error("remainder not below divisor");

endmodule

### tb/sv/ptat_ctat_temperature_calc_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for ptat_ctat_temperature_calc: directed and random sample
// pairs under several calibration settings. Depends on ptc_pkg and the block's RTL.
module ptat_ctat_temperature_calc_test;
  import ptc_pkg::*;

  localparam int ADC_BITS = 16;
  localparam int LATENCY = 4 + 43; // pipeline depth of the block, its LAT

  // Holds the calibration words, predicts each item's temperature and checks results.
  class temp_scoreboard;
    logic [11:0] cal [6];
    logic signed [15:0] temp_q [$];
    logic err_q [$];
    int errors;

    function new();
      foreach (cal[k]) cal[k] = '0;
      errors = 0;
    endfunction

    function void write_cal(logic [2:0] idx, logic [11:0] val);
      if (idx < 6) cal[idx] = val;
    endfunction

    // Two-point formula, 64-bit signed, truncating divide, then floor shift and saturation.
    function void note_item(logic [15:0] ctat, logic [15:0] ptat);
      longint tc, tp, tl, th, vpl, vph, vcl, vch, num, den, q;
      tc = ctat & ((64'd1 << ADC_BITS) - 1);
      tp = ptat & ((64'd1 << ADC_BITS) - 1);
      tl = cal[REG_LOW_TEMP];   th = cal[REG_HIGH_TEMP];
      vpl = cal[REG_PTAT_LOW];  vph = cal[REG_PTAT_HIGH];
      vcl = cal[REG_CTAT_LOW];  vch = cal[REG_CTAT_HIGH];
      num = tl*vph*tc - vpl*th*tc - tl*vch*tp + th*vcl*tp;
      den = vcl*tp - vch*tp - vpl*tc + vph*tc;
      if (den == 0) begin
        temp_q.push_back(16'sd0);
        err_q.push_back(1'b1);
      end else begin
        q = num / den;
        q = q >>> 4;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        temp_q.push_back(q[15:0]);
        err_q.push_back(1'b0);
      end
    endfunction

    function void check_result(logic signed [15:0] temp, logic err);
      logic signed [15:0] exp_t;
      logic exp_e;
      if (temp_q.size() == 0) begin
        $display("%0t: unexpected result temp=%0d err=%0b", $time, temp, err);
        errors++;
        return;
      end
      exp_t = temp_q.pop_front();
      exp_e = err_q.pop_front();
      if (temp !== exp_t) begin
        $display("%0t: temperature expected %0d actual %0d", $time, exp_t, temp);
        errors++;
      end
      if (err !== exp_e) begin
        $display("%0t: divide_error expected %0b actual %0b", $time, exp_e, err);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [15:0] ctat_sample_i = '0;
  logic [15:0] ptat_sample_i = '0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [11:0] cfg_data_i = '0;
  logic done;
  logic signed [15:0] temperature_deg_o;
  logic divide_error_o;

  temp_scoreboard sb = new();

  always #5 clk_i = ~clk_i;

  ptat_ctat_temperature_calc #(.ADC_BITS(ADC_BITS)) u_top (
    .clk_i, .rst_ni, .start, .busy, .ctat_sample_i, .ptat_sample_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .done, .temperature_deg_o, .divide_error_o
  );

  // Results are sampled at the rising edge that ends their cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done) sb.check_result(temperature_deg_o, divide_error_o);
  end

  // Drives one register write; the enable stays high for back-to-back writes
  // and is lowered by load_cal once the last one is done.
  task automatic write_reg(logic [2:0] idx, logic [11:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_cal(idx, val);
    @(negedge clk_i);
  endtask

  task automatic load_cal(logic [11:0] tl, th, vpl, vph, vcl, vch);
    write_reg(REG_LOW_TEMP, tl);
    write_reg(REG_HIGH_TEMP, th);
    write_reg(REG_PTAT_LOW, vpl);
    write_reg(REG_PTAT_HIGH, vph);
    write_reg(REG_CTAT_LOW, vcl);
    write_reg(REG_CTAT_HIGH, vch);
    cfg_we_i <= 1'b0;
  endtask

  // Presents one sample pair and holds it until accepted. start stays high
  // into the next item when there is no gap, so it is not lowered here but by idle_gap and drain.
  task automatic send_item(logic [15:0] ctat, logic [15:0] ptat);
    start <= 1'b1;
    ctat_sample_i <= ctat;
    ptat_sample_i <= ptat;
    do @(posedge clk_i); while (busy);
    sb.note_item(ctat, ptat);
    @(negedge clk_i);
  endtask

  task automatic idle_gap(bit quiet);
    int gap;
    if (quiet) return;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (gap == 0) return;
    start <= 1'b0;
    repeat (gap) @(negedge clk_i);
  endtask

  // Lets the pipeline drain before touching the calibration words.
  task automatic drain();
    start <= 1'b0;
    while (sb.temp_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  // Typical calibration: PTAT rising, CTAT falling with temperature.
  task automatic random_cal();
    logic [11:0] vpl, vcl;
    vpl = $urandom_range(200, 2000);
    vcl = $urandom_range(2000, 4000);
    load_cal($urandom_range(0, 600), $urandom_range(1000, 4095), vpl,
             vpl + $urandom_range(1, 2000), vcl, vcl - $urandom_range(1, 1900));
  endtask

  task automatic random_items(int n);
    bit quiet;
    int mode;
    quiet = $urandom_range(0, 3) == 0; // some stretches without gaps
    repeat (n) begin
      mode = $urandom_range(0, 9);
      if (mode < 7)
        send_item($urandom_range(0, 4095), $urandom_range(0, 4095));
      else if (mode < 9)
        send_item($urandom, $urandom);
      else
        send_item($urandom_range(0, 1) ? 16'hFFFF : 16'h0000, $urandom);
      idle_gap(quiet);
    end
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset calibration: every denominator is zero.
    send_item(16'h0000, 16'h0000);
    send_item(16'hFFFF, 16'hFFFF);
    drain();

    // Unknown register indexes must be ignored.
    write_reg(3'd6, 12'hFFF);
    write_reg(3'd7, 12'hABC);
    load_cal(12'd400, 12'd1360, 12'd1000, 12'd1400, 12'd3000, 12'd2600);
    send_item(16'h0000, 16'h0000);       // zero denominator
    send_item(16'hFFFF, 16'h0000);
    send_item(16'h0000, 16'hFFFF);
    send_item(16'hFFFF, 16'hFFFF);
    send_item(16'd2800, 16'd1200);       // mid-range reading
    send_item(16'd3000, 16'd1000);       // low calibration point
    send_item(16'd2600, 16'd1400);
    send_item(16'h5555, 16'hAAAA);
    send_item(16'hAAAA, 16'h5555);
    send_item(16'd1, 16'd1);
    drain();

    // Extreme calibration words, including a set that drives negative saturation.
    load_cal(12'hFFF, 12'h000, 12'h000, 12'hFFF, 12'h001, 12'h000);
    send_item(16'h0001, 16'hFFFF);
    send_item(16'hFFFF, 16'h0001);
    send_item(16'h0000, 16'h0001);
    send_item(16'h0001, 16'h0000);
    drain();
    load_cal(12'h000, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'h000);
    send_item(16'hFFFF, 16'h0001);
    send_item(16'h0001, 16'hFFFF);
    send_item(16'h1234, 16'h8000);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 5) load_cal(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
      else random_cal();
      random_items(phase == 5 ? 50 : 120);
      drain();
    end

    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
